// File: hdl/ccs_pkg.sv
// Shared types and character constants for the C comment stripper.
`default_nettype none

package ccs_pkg;

    // Lexer modes
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_STRING = 3'd1,
        MODE_CHAR   = 3'd2,
        MODE_SLASH  = 3'd3,
        MODE_LINE   = 3'd4,
        MODE_BLOCK  = 3'd5
    } ccs_mode_t;

    // Characters the lexer looks for
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // One queued request: the text bytes caused by one source byte
    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       two_bytes;
    } ccs_rec_t;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic nonempty;
    } ccs_qstat_t;

endpackage

`default_nettype wire

// File: hdl/ccs_front.sv
// Lexer front end: accepts source bytes and turns those that produce text into queued requests.
`default_nettype none

module ccs_front
    import ccs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire ccs_qstat_t qstat,
    output logic            push,
    output ccs_rec_t        rec
);

    ccs_mode_t mode_reg, mode_next;
    logic      str_esc_reg, str_esc_next;
    logic      chr_esc_reg, chr_esc_next;
    logic      line_esc_reg, line_esc_next;
    logic      star_reg, star_next;
    logic      accept;

    // Take a byte whenever the queue has room
    assign in_ready = !qstat.full;
    assign accept   = in_valid && in_ready;

    // Hold lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_NORMAL;
            str_esc_reg  <= 1'b0;
            chr_esc_reg  <= 1'b0;
            line_esc_reg <= 1'b0;
            star_reg     <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            str_esc_reg  <= str_esc_next;
            chr_esc_reg  <= chr_esc_next;
            line_esc_reg <= line_esc_next;
            star_reg     <= star_next;
        end
    end

    // Classify the byte: next mode and the bytes to emit
    always_comb
    begin
        mode_next       = mode_reg;
        str_esc_next    = str_esc_reg;
        chr_esc_next    = chr_esc_reg;
        line_esc_next   = line_esc_reg;
        star_next       = star_reg;
        push            = 1'b0;
        rec.first_byte  = in_byte;
        rec.second_byte = in_byte;
        rec.two_bytes   = 1'b0;
        if (accept)
        begin
            unique case (mode_reg)
                MODE_STRING:
                begin
                    push = 1'b1;
                    if (in_byte == CH_DQUOTE && !str_esc_reg)
                        mode_next = MODE_NORMAL;
                    str_esc_next = (in_byte == CH_BSLASH) && !str_esc_reg;
                end
                MODE_CHAR:
                begin
                    push = 1'b1;
                    if (in_byte == CH_SQUOTE && !chr_esc_reg)
                        mode_next = MODE_NORMAL;
                    chr_esc_next = (in_byte == CH_BSLASH) && !chr_esc_reg;
                end
                MODE_SLASH:
                begin
                    if (in_byte == CH_SLASH)
                        mode_next = MODE_LINE;
                    else if (in_byte == CH_STAR)
                        mode_next = MODE_BLOCK;
                    else
                    begin
                        // release the held slash, then treat the byte as normal text
                        push           = 1'b1;
                        rec.first_byte = CH_SLASH;
                        rec.two_bytes  = 1'b1;
                        if (in_byte == CH_DQUOTE)
                            mode_next = MODE_STRING;
                        else if (in_byte == CH_SQUOTE)
                            mode_next = MODE_CHAR;
                        else
                            mode_next = MODE_NORMAL;
                    end
                end
                MODE_LINE:
                begin
                    if (in_byte == CH_NL && !line_esc_reg)
                    begin
                        push           = 1'b1;
                        rec.first_byte = CH_NL;
                        mode_next      = MODE_NORMAL;
                    end
                    line_esc_next = (in_byte == CH_BSLASH) && !line_esc_reg;
                end
                MODE_BLOCK:
                begin
                    if (in_byte == CH_SLASH && star_reg)
                    begin
                        push           = 1'b1;
                        rec.first_byte = CH_SPACE;
                        mode_next      = MODE_NORMAL;
                    end
                    star_next = (in_byte == CH_STAR);
                end
                default:
                begin
                    // normal text, and the unused codes
                    if (in_byte == CH_SLASH)
                        mode_next = MODE_SLASH;
                    else
                    begin
                        push = 1'b1;
                        if (in_byte == CH_DQUOTE)
                            mode_next = MODE_STRING;
                        else if (in_byte == CH_SQUOTE)
                            mode_next = MODE_CHAR;
                        else
                            mode_next = MODE_NORMAL;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/ccs_queue.sv
// Short request queue between the lexer front end and the output back end.
`default_nettype none

module ccs_queue
    import ccs_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire ccs_rec_t push_rec,
    input  wire logic     pop,
    output ccs_rec_t      head_rec,
    output ccs_qstat_t    qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ccs_rec_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign qstat.full     = (count_reg == CNT_W'(DEPTH));
    assign qstat.nonempty = (count_reg != '0);
    assign head_rec       = mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store requests
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full || pop)
        else $error("request pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> qstat.nonempty)
        else $error("request popped from an empty queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("fill count did not follow a push");

endmodule

`default_nettype wire

// File: hdl/ccs_back.sv
// Output back end: plays out each request as one or two text bytes.
`default_nettype none

module ccs_back
    import ccs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ccs_qstat_t qstat,
    input  wire ccs_rec_t   head_rec,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last
);

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       pend_valid_reg;
    logic [7:0] pend_byte_reg;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign pop       = out_free && !pend_valid_reg && qstat.nonempty;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    // Control: output valid and pending second byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg  <= qstat.nonempty;
                pend_valid_reg <= qstat.nonempty && head_rec.two_bytes;
            end
        end
    end

    // Payload: load the next byte when the output register frees up
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_byte_reg <= pend_byte_reg;
                out_last_reg <= 1'b1;
            end
            else
            begin
                out_byte_reg  <= head_rec.first_byte;
                out_last_reg  <= !head_rec.two_bytes;
                pend_byte_reg <= head_rec.second_byte;
            end
        end
    end

    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("second byte pending with no first byte shown");

    a_not_last_has_pend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_last_reg |-> pend_valid_reg)
        else $error("run left open with no second byte pending");

    a_pend_goes_last: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && out_free |=> out_valid_reg && out_last_reg)
        else $error("second byte not shown as last of its run");

endmodule

`default_nettype wire

// File: hdl/c_comment_stripper.sv
// A source byte's text is registered in the request queue and then in the output register.
// Throughput: one source byte per cycle while the queue has room; a two-byte run holds
// the output for both bytes, and the request queue (QUEUE_DEPTH entries) lets input
// continue meanwhile. Bytes that open or sit inside a comment produce no output.
// Reset (rst_n low, asynchronous): lexer in normal mode, escape and star flags clear,
// queue empty, output idle.
`default_nettype none

module c_comment_stripper
    import ccs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast    // last_of_run
);

    ccs_qstat_t qstat;
    ccs_rec_t   push_rec;
    ccs_rec_t   head_rec;
    logic       push;
    logic       pop;

    ccs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .qstat    (qstat),
        .push     (push),
        .rec      (push_rec)
    );

    ccs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .qstat    (qstat)
    );

    ccs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .head_rec  (head_rec),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire
